[rtl/tksa_pkg.sv]
package tksa_pkg;

	localparam int KEY_W           = 24;
	localparam int VAL_W           = 24;
	localparam int IDX_W           = 6;
	localparam int RANK_W          = 7;
	localparam int TOP_W           = 7;
	localparam int SUM_W           = 30;
	localparam int MAX_RECORDS_DEF = 64;

	typedef struct packed {
		logic [KEY_W-1:0] sort_key;
		logic [VAL_W-1:0] item_value;
		logic             last_record;
	} item_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [IDX_W-1:0]  record_index;
		logic [VAL_W-1:0]  ranked_value;
		logic [VAL_W-1:0]  average;
		logic              invalid;
		logic              final_res;
	} result_t;

	// one stored record
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] index;
	} entry_t;

endpackage

[rtl/top_k_sort_average_top.sv]
// Top-K stable sort and average.
// Records enter on item when start is high and busy is low; each is kept in a
// single-port-write record memory, sorted by descending key (ties keep arrival
// order). A record into an empty store is written straight to entry 0; otherwise
// the insertion walks the memory one entry per cycle, moving each smaller-key
// entry up by one slot with a pipelined read.
// The record flagged last_record closes the data set. The block then either
// gives a single result with invalid set (K zero or above the count), or
// reads the top K entries one per cycle and strobes results rank 1..K-1, then
// runs a bit-serial divide for the average and strobes the final one. Each
// result sits on result for one cycle with result_strobe high; the receiver
// cannot stall and must take it then. busy is high while any work is pending.
// top_count must be written through cfg_wr_en/cfg_wr_data only while idle;
// the block does not enforce this. Reset clears the record count and sets K
// to 1; memory contents are not cleared, as only written entries are ever
// read.
module top_k_sort_average_top #(
	parameter int MAX_RECORDS = tksa_pkg::MAX_RECORDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  tksa_pkg::item_t            item,
	input  logic                       cfg_wr_en,
	input  logic [tksa_pkg::TOP_W-1:0] cfg_wr_data,
	output logic                       result_strobe,
	output tksa_pkg::result_t          result
);

	localparam int ADDR_W = $clog2(MAX_RECORDS);
	localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
	localparam int TOP_W  = tksa_pkg::TOP_W;
	localparam int SUM_W  = tksa_pkg::SUM_W;
	localparam int IDX_W  = tksa_pkg::IDX_W;
	localparam int VAL_W  = tksa_pkg::VAL_W;
	localparam int KEY_W  = tksa_pkg::KEY_W;
	localparam int RANK_W = tksa_pkg::RANK_W;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SHIFT = 7'b0000010,
		ST_PLACE = 7'b0000100,
		ST_CHECK = 7'b0001000,
		ST_RPT   = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_HOLD  = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	logic                last_q;
	logic [ADDR_W-1:0]   pos_q;
	logic [CNT_W-1:0]    count_q;
	logic [TOP_W-1:0]    top_count_q;
	logic [ADDR_W-1:0]   rank_q;
	logic [SUM_W-1:0]    sum_q;
	logic [VAL_W-1:0]    fin_val_q;
	logic [IDX_W-1:0]    fin_idx_q;
	logic                strobe_q;
	tksa_pkg::result_t   result_q;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	tksa_pkg::entry_t    mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;
	tksa_pkg::entry_t    mem_rdata;

	logic                div_start;
	logic                div_done;
	logic [SUM_W-1:0]    div_quot;

	logic                accept;
	logic                has_room;
	logic [SUM_W-1:0]    sum_next;
	logic [RANK_W-1:0]   rank_next;
	logic                k_bad;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign has_room  = count_q < CNT_W'(MAX_RECORDS);
	assign sum_next  = sum_q + SUM_W'(mem_rdata.value);
	assign rank_next = RANK_W'(rank_q) + RANK_W'(1);
	assign k_bad     = (top_count_q == '0) || (top_count_q > TOP_W'(count_q));
	assign div_start = (state_q == ST_RPT) && (rank_next == RANK_W'(top_count_q));

	// Memory control. Shift writes go to pos, reads to pos-2: never the same entry.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = '{key: key_q, value: val_q, index: IDX_W'(count_q)};
		mem_re    = 1'b0;
		mem_raddr = pos_q - ADDR_W'(2);
		case (state_q)
			ST_IDLE: begin
				if (accept && has_room) begin
					if (count_q == '0) begin
						mem_we    = 1'b1;
						mem_waddr = '0;
						mem_wdata = '{key: item.sort_key, value: item.item_value,
							index: '0};
					end else begin
						mem_re    = 1'b1;
						mem_raddr = ADDR_W'(count_q - CNT_W'(1));
					end
				end
			end
			ST_SHIFT: begin
				mem_we = 1'b1;
				if (mem_rdata.key < key_q) begin
					mem_wdata = mem_rdata;
					mem_re    = (pos_q != ADDR_W'(1));
				end
			end
			ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
			end
			ST_CHECK: begin
				mem_re    = last_q && !k_bad;
				mem_raddr = '0;
			end
			ST_RPT: begin
				mem_re    = !div_start;
				mem_raddr = rank_q + ADDR_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			top_count_q <= TOP_W'(1);
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_wr_en) begin
				top_count_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!has_room) begin
							state_q <= ST_CHECK;
						end else if (count_q == '0) begin
							count_q <= CNT_W'(1);
							state_q <= ST_CHECK;
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (mem_rdata.key < key_q) begin
						if (pos_q == ADDR_W'(1)) begin
							state_q <= ST_PLACE;
						end
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_CHECK;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (k_bad) begin
						strobe_q <= 1'b1;
						count_q  <= '0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_RPT;
					end
				end
				ST_RPT: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end else begin
						strobe_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						strobe_q <= 1'b1;
						count_q  <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q  <= item.sort_key;
				val_q  <= item.item_value;
				last_q <= item.last_record;
				pos_q  <= ADDR_W'(count_q);
			end
			ST_SHIFT: begin
				if (mem_rdata.key < key_q) begin
					pos_q <= pos_q - ADDR_W'(1);
				end
			end
			ST_CHECK: begin
				rank_q   <= '0;
				sum_q    <= '0;
				result_q <= '{rank: '0, record_index: '0, ranked_value: '0,
					average: '0, invalid: 1'b1, final_res: 1'b1};
			end
			ST_RPT: begin
				sum_q  <= sum_next;
				rank_q <= rank_q + ADDR_W'(1);
				if (div_start) begin
					fin_val_q <= mem_rdata.value;
					fin_idx_q <= mem_rdata.index;
				end else begin
					result_q <= '{rank: rank_next, record_index: mem_rdata.index,
						ranked_value: mem_rdata.value, average: '0, invalid: 1'b0,
						final_res: 1'b0};
				end
			end
			ST_DIV: begin
				result_q <= '{rank: RANK_W'(top_count_q), record_index: fin_idx_q,
					ranked_value: fin_val_q, average: div_quot[VAL_W-1:0],
					invalid: 1'b0, final_res: 1'b1};
			end
			default: begin
			end
		endcase
	end

	tksa_mem #(
		.DEPTH (MAX_RECORDS),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	tksa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_next),
		.divisor (top_count_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	assign result_strobe = strobe_q;
	assign result        = result_q;

	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result strobe without pending work");

	a_invalid_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.invalid |-> result.final_res)
		else $error("invalid result not marked final");

	a_avg_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.final_res |-> result.average == '0)
		else $error("average on a non-final result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RECORDS))
		else $error("record count beyond store depth");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_waddr != mem_raddr)
		else $error("read and write to the same entry");

	a_final_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.final_res |-> !busy)
		else $error("final result while still busy");

endmodule

[rtl/tksa_mem.sv]
module tksa_mem #(
	parameter int DEPTH  = tksa_pkg::MAX_RECORDS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  tksa_pkg::entry_t    wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output tksa_pkg::entry_t    rdata
);

	tksa_pkg::entry_t mem_q [DEPTH];
	tksa_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/tksa_div.sv]
module tksa_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tksa_pkg::SUM_W-1:0] dividend,
	input  logic [tksa_pkg::TOP_W-1:0] divisor,
	output logic                       done,
	output logic [tksa_pkg::SUM_W-1:0] quotient
);

	localparam int SUM_W  = tksa_pkg::SUM_W;
	localparam int TOP_W  = tksa_pkg::TOP_W;
	localparam int STEP_W = $clog2(SUM_W);

	logic [SUM_W-1:0]  dvd_q;
	logic [TOP_W-1:0]  rem_q;
	logic [TOP_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;

	logic [TOP_W:0]    trial;
	logic              fits;
	logic [TOP_W:0]    diff;

	// restoring division, one quotient bit per cycle; remainder stays below divisor
	always_comb begin
		trial = {rem_q, dvd_q[SUM_W-1]};
		fits  = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (step_q == STEP_W'(SUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[TOP_W-1:0] : trial[TOP_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
